// ===== rtl/mesh_packet_relay_table_assert.svh =====
// assertion macros for the packet relay table
`ifndef MESH_PACKET_RELAY_TABLE_ASSERT_SVH
`define MESH_PACKET_RELAY_TABLE_ASSERT_SVH
`ifndef SYNTH
`define MPRT_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define MPRT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define MPRT_ASSERT_IMP(label, clk, rst, a, c)
`define MPRT_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/mprt_pkg.sv =====
// shared types and constants for the packet relay table
`default_nettype none
package mprt_pkg;
  localparam int PendingDepthDef = 16;
  localparam int AckDepthDef = 16;
  localparam int InboxDepthDef = 16;
  localparam int MaxResults = 16;

  typedef enum logic [1:0] {
    CMD_RECEIVE = 2'd0, CMD_SUBMIT = 2'd1, CMD_TX_ROUND = 2'd2, CMD_ACK_ROUND = 2'd3
  } cmd_t;

  localparam logic [1:0] TYPE_NORMAL = 2'd0;
  localparam logic [1:0] TYPE_ACK = 2'd1;
  localparam logic [1:0] TYPE_RETRY1 = 2'd2;
  localparam logic [1:0] TYPE_RETRY2 = 2'd3;

  localparam logic [3:0] ACT_DROPPED = 4'd0;
  localparam logic [3:0] ACT_DELIVERED = 4'd1;
  localparam logic [3:0] ACT_DUP_OURS = 4'd2;
  localparam logic [3:0] ACT_RELAY = 4'd3;
  localparam logic [3:0] ACT_DUP_RELAY = 4'd4;
  localparam logic [3:0] ACT_ACK = 4'd5;
  localparam logic [3:0] ACT_SUBMIT = 4'd6;
  localparam logic [3:0] ACT_TRANSMIT = 4'd7;
  localparam logic [3:0] ACT_NOTHING = 4'd8;
  localparam logic [3:0] ACT_FULL = 4'd9;

  localparam logic [1:0] REG_NODE_ID = 2'd0;

  typedef struct packed {
    logic [2:0] dest;
    logic [2:0] sender;
    logic [1:0] ptype;
    logic [7:0] id;
  } hdr_t;

  typedef struct packed {
    logic [3:0] action;
    logic       ack_matched;
    logic       ack_queue_full;
    hdr_t       tx;
    logic [3:0] slot;
    logic       last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PEND_RD, ST_PEND_CHK, ST_ACK_RD, ST_ACK_CHK, ST_INBOX_RD, ST_INBOX_CHK,
    ST_DECIDE, ST_TX_RD, ST_TX_CHK, ST_AR_RD, ST_AR_CHK, ST_EMIT, ST_WAIT
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/mesh_packet_relay_table.sv =====
// top level of the packet relay table engine
// usage: items arrive on valid/stall with command and header fields; results leave on
// out_valid/out_stall, one per receive or submit, one per sent entry for rounds
// (last marks the final one), a round with nothing to send gives one result.
// a dropped packet goes straight to the output; a receive walks a 16-entry table
// (by default) through the registered-read memory, a read state and a check state
// per slot; rounds walk likewise, holding each sent entry until the next is found.
// the next item is taken only after the last result of the current one is loaded into
// the output register; a held result waits there while the receiver stalls, and the
// engine waits with it before loading another.
// reset clears the valid bits, inbox fill and pointer, and node_id; table contents are
// left as they are. node_id is written over the apb port at address 0; the user must
// write it only while idle, which the block itself does not enforce.
`default_nettype none
module mesh_packet_relay_table
  import mprt_pkg::*;
#(
  parameter int PENDING_DEPTH = PendingDepthDef,
  parameter int ACK_DEPTH = AckDepthDef,
  parameter int INBOX_DEPTH = InboxDepthDef
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [0:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  wire logic [2:0] dest,
  input  wire logic [2:0] sender,
  input  wire logic [1:0] pkt_type,
  input  wire logic [7:0] pkt_id,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      action,
  output logic            ack_matched,
  output logic            ack_queue_full,
  output logic [2:0]      tx_dest,
  output logic [2:0]      tx_sender,
  output logic [1:0]      tx_type,
  output logic [7:0]      tx_id,
  output logic [3:0]      slot,
  output logic            last
);
  import mprt_pkg::*;
  localparam int PW = $clog2(PENDING_DEPTH);
  localparam int AW = $clog2(ACK_DEPTH);
  localparam int IW = $clog2(INBOX_DEPTH);
  localparam int SW = (PW > AW) ? ((PW > IW) ? PW : IW) : ((AW > IW) ? AW : IW);

  logic [2:0] node_id;
  assign pready = 1'b1;
  assign prdata = {29'd0, node_id};
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= 3'd0;
    end else if (psel && penable && pwrite && paddr == REG_NODE_ID[0:0]) begin
      node_id <= pwdata[2:0];
    end
  end

  // memories
  hdr_t pend_mem [PENDING_DEPTH];
  hdr_t ack_mem [ACK_DEPTH];
  logic [7:0] inbox_mem [INBOX_DEPTH];
  logic [PENDING_DEPTH-1:0] pend_v, pend_v_next;
  logic [ACK_DEPTH-1:0] ack_v, ack_v_next;
  logic [IW:0] inbox_fill, inbox_fill_next;
  logic [IW-1:0] inbox_wp, inbox_wp_next;
  hdr_t pend_rd, ack_rd;
  logic [7:0] inbox_rd;
  logic pend_we, ack_we, inbox_we;
  hdr_t pend_wd, ack_wd;
  logic [PW-1:0] pend_wa;
  logic [AW-1:0] ack_wa;

  state_t state, state_next;
  logic [SW:0] idx, idx_next;
  cmd_t cmd;
  hdr_t ih;
  logic matched, matched_next, found, found_next, afull, afull_next;
  logic [SW-1:0] fslot, fslot_next;
  logic [4:0] nsent, nsent_next;
  logic emit_last, emit_last_next;
  logic held, held_next;
  state_t ret, ret_next;
  result_t res, res_next;
  logic load, obusy;
  result_t odata;

  always_ff @(posedge clk) begin
    pend_rd <= pend_mem[idx[PW-1:0]];
    ack_rd <= ack_mem[idx[AW-1:0]];
    inbox_rd <= inbox_mem[idx[IW-1:0]];
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    if (ack_we) ack_mem[ack_wa] <= ack_wd;
    if (inbox_we) inbox_mem[inbox_wp] <= ih.id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend_v <= '0;
      ack_v <= '0;
      inbox_fill <= '0;
      inbox_wp <= '0;
    end else begin
      state <= state_next;
      pend_v <= pend_v_next;
      ack_v <= ack_v_next;
      inbox_fill <= inbox_fill_next;
      inbox_wp <= inbox_wp_next;
    end
  end
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cmd <= cmd_t'(command);
      ih <= '{dest, sender, pkt_type, pkt_id};
    end
    idx <= idx_next;
    matched <= matched_next;
    found <= found_next;
    afull <= afull_next;
    fslot <= fslot_next;
    nsent <= nsent_next;
    emit_last <= emit_last_next;
    held <= held_next;
    ret <= ret_next;
    res <= res_next;
  end

  assign in_stall = (state != ST_IDLE);

  function automatic result_t mk(logic [3:0] a, logic m, logic f, logic [SW-1:0] s);
    result_t r;
    r = '0;
    r.action = a;
    r.ack_matched = m;
    r.ack_queue_full = f;
    r.slot = 4'(s);
    return r;
  endfunction

  always_comb begin
    state_next = state;
    idx_next = idx;
    matched_next = matched;
    found_next = found;
    afull_next = afull;
    fslot_next = fslot;
    nsent_next = nsent;
    emit_last_next = emit_last;
    held_next = held;
    ret_next = ret;
    res_next = res;
    pend_v_next = pend_v;
    ack_v_next = ack_v;
    inbox_fill_next = inbox_fill;
    inbox_wp_next = inbox_wp;
    pend_we = 1'b0;
    ack_we = 1'b0;
    inbox_we = 1'b0;
    pend_wd = ih;
    ack_wd = ih;
    pend_wa = fslot[PW-1:0];
    ack_wa = fslot[AW-1:0];
    load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        idx_next = '0;
        matched_next = 1'b0;
        found_next = 1'b0;
        afull_next = 1'b0;
        nsent_next = '0;
        held_next = 1'b0;
        if (in_valid) begin
          unique case (cmd_t'(command))
            CMD_RECEIVE: begin
              if (sender == node_id || dest > 3'd3 || pkt_type == TYPE_RETRY1) begin
                res_next = mk(ACT_DROPPED, 1'b0, 1'b0, '0);
                emit_last_next = 1'b1;
                ret_next = ST_IDLE;
                state_next = ST_EMIT;
              end else if (dest == node_id && pkt_type != TYPE_ACK) begin
                state_next = ST_INBOX_RD;
              end else begin
                state_next = ST_PEND_RD;
              end
            end
            CMD_SUBMIT: state_next = ST_DECIDE;
            CMD_TX_ROUND: state_next = ST_TX_RD;
            CMD_ACK_ROUND: state_next = ST_AR_RD;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      // search pending: acks find header match, relays find id match
      ST_PEND_RD: state_next = ST_PEND_CHK;
      ST_PEND_CHK: begin
        if (pend_v[idx[PW-1:0]] && pend_rd.id == ih.id && (ih.ptype != TYPE_ACK ||
            (pend_rd.dest == ih.sender && pend_rd.sender == ih.dest))) begin
          found_next = 1'b1;
          fslot_next = SW'(idx[PW-1:0]);
          state_next = ST_DECIDE;
        end else if (idx == (SW+1)'(PENDING_DEPTH - 1)) begin
          state_next = ST_DECIDE;
        end else begin
          idx_next = idx + 1'b1;
          state_next = ST_PEND_RD;
        end
      end
      ST_INBOX_RD: state_next = ST_INBOX_CHK;
      ST_INBOX_CHK: begin
        if (idx < (SW+1)'(inbox_fill) && inbox_rd == ih.id) begin
          found_next = 1'b1;
          fslot_next = SW'(idx[IW-1:0]);
          state_next = ST_DECIDE;
        end else if (idx == (SW+1)'(INBOX_DEPTH - 1)) begin
          state_next = ST_DECIDE;
        end else begin
          idx_next = idx + 1'b1;
          state_next = ST_INBOX_RD;
        end
      end
      ST_DECIDE: begin
        emit_last_next = 1'b1;
        ret_next = ST_IDLE;
        state_next = ST_EMIT;
        if (cmd == CMD_SUBMIT || (ih.ptype != TYPE_ACK && ih.dest != node_id)) begin
          if (cmd == CMD_RECEIVE && found) begin
            res_next = mk(ACT_DUP_RELAY, 1'b0, 1'b0, fslot);
          end else if (&pend_v) begin
            res_next = mk(ACT_FULL, 1'b0, 1'b0, '0);
          end else begin
            for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
              if (!pend_v[i]) fslot_next = SW'(i);
            end
            state_next = ST_ACK_CHK;
            ret_next = ST_PEND_CHK;
          end
        end else begin
          if (ih.ptype == TYPE_ACK) begin
            if (found) pend_v_next[fslot[PW-1:0]] = 1'b0;
            matched_next = found;
          end else if (!found) begin
            inbox_we = 1'b1;
            fslot_next = SW'(inbox_wp);
            inbox_wp_next = IW'((IW+1)'(inbox_wp) + 1'b1 == (IW+1)'(INBOX_DEPTH) ? 0
                            : inbox_wp + 1'b1);
            if (inbox_fill != (IW+1)'(INBOX_DEPTH)) inbox_fill_next = inbox_fill + 1'b1;
          end
          state_next = ST_ACK_RD;
        end
      end
      // write stage: pending enqueue (the ack enqueue is done in ST_ACK_RD)
      ST_ACK_CHK: begin
        pend_we = 1'b1;
        pend_v_next[fslot[PW-1:0]] = 1'b1;
        res_next = mk((cmd == CMD_SUBMIT) ? ACT_SUBMIT : ACT_RELAY, 1'b0, 1'b0, fslot);
        state_next = ST_EMIT;
        ret_next = ST_IDLE;
      end
      ST_ACK_RD: begin
        logic [SW-1:0] fr;
        logic q;
        fr = '0;
        q = (ih.ptype != TYPE_ACK) || (ih.dest != node_id);
        for (int i = ACK_DEPTH - 1; i >= 0; i--) begin
          if (!ack_v[i]) fr = SW'(i);
        end
        if (ih.ptype == TYPE_ACK) ack_wd = ih;
        else ack_wd = '{ih.sender, node_id, TYPE_ACK, ih.id};
        ack_wa = fr[AW-1:0];
        if (q && !(&ack_v)) begin
          ack_v_next[fr[AW-1:0]] = 1'b1;
          ack_we = 1'b1;
        end
        fslot_next = fr;
        if (ih.ptype == TYPE_ACK) begin
          res_next = mk(ACT_ACK, matched, q && (&ack_v),
                        (q && !(&ack_v)) ? fr : '0);
        end else begin
          res_next = mk(found ? ACT_DUP_OURS : ACT_DELIVERED, 1'b0, &ack_v, fslot);
        end
        state_next = ST_EMIT;
        ret_next = ST_IDLE;
      end
      ST_TX_RD: state_next = ST_TX_CHK;
      ST_TX_CHK: begin
        logic lastslot;
        lastslot = (idx == (SW+1)'(PENDING_DEPTH - 1)) || (nsent == 5'(MaxResults - 1));
        if (pend_v[idx[PW-1:0]] && pend_rd.ptype != TYPE_ACK) begin
          if (held) begin
            // send the held transfer first, then revisit this slot
            held_next = 1'b0;
            emit_last_next = 1'b0;
            ret_next = ST_TX_RD;
            state_next = ST_EMIT;
          end else begin
            res_next = mk(ACT_TRANSMIT, 1'b0, 1'b0, SW'(idx[PW-1:0]));
            res_next.tx = pend_rd;
            pend_wd = pend_rd;
            pend_wa = idx[PW-1:0];
            unique case (pend_rd.ptype)
              TYPE_NORMAL: begin
                pend_wd.ptype = TYPE_RETRY1;
                pend_we = 1'b1;
              end
              TYPE_RETRY1: begin
                res_next.tx.ptype = TYPE_NORMAL;
                pend_wd.ptype = TYPE_RETRY2;
                pend_we = 1'b1;
              end
              default: pend_v_next[idx[PW-1:0]] = 1'b0;
            endcase
            nsent_next = nsent + 1'b1;
            idx_next = idx + 1'b1;
            if (lastslot) begin
              emit_last_next = 1'b1;
              ret_next = ST_IDLE;
              state_next = ST_EMIT;
            end else begin
              held_next = 1'b1;
              state_next = ST_TX_RD;
            end
          end
        end else begin
          if (pend_v[idx[PW-1:0]]) pend_v_next[idx[PW-1:0]] = 1'b0;
          idx_next = idx + 1'b1;
          if (idx == (SW+1)'(PENDING_DEPTH - 1)) state_next = ST_WAIT;
          else state_next = ST_TX_RD;
        end
      end
      ST_AR_RD: state_next = ST_AR_CHK;
      ST_AR_CHK: begin
        logic lastslot;
        lastslot = (idx == (SW+1)'(ACK_DEPTH - 1)) || (nsent == 5'(MaxResults - 1));
        if (ack_v[idx[AW-1:0]]) begin
          if (held) begin
            held_next = 1'b0;
            emit_last_next = 1'b0;
            ret_next = ST_AR_RD;
            state_next = ST_EMIT;
          end else begin
            res_next = mk(ACT_TRANSMIT, 1'b0, 1'b0, SW'(idx[AW-1:0]));
            res_next.tx = ack_rd;
            ack_v_next[idx[AW-1:0]] = 1'b0;
            nsent_next = nsent + 1'b1;
            idx_next = idx + 1'b1;
            if (lastslot) begin
              emit_last_next = 1'b1;
              ret_next = ST_IDLE;
              state_next = ST_EMIT;
            end else begin
              held_next = 1'b1;
              state_next = ST_AR_RD;
            end
          end
        end else begin
          idx_next = idx + 1'b1;
          if (idx == (SW+1)'(ACK_DEPTH - 1)) state_next = ST_WAIT;
          else state_next = ST_AR_RD;
        end
      end
      // end of a walk: send the held entry as last, or report an empty round
      ST_WAIT: begin
        ret_next = ST_IDLE;
        emit_last_next = 1'b1;
        if (held) begin
          held_next = 1'b0;
          state_next = ST_EMIT;
        end else if (nsent == '0) begin
          res_next = mk(ACT_NOTHING, 1'b0, 1'b0, '0);
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!obusy) begin
          load = 1'b1;
          state_next = ret;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // last flag travels beside the result until it is loaded
  result_t lres;
  always_comb begin
    lres = res;
    lres.last = emit_last;
  end

  mprt_out_reg u_out (
    .clk(clk), .rst(rst), .load(load), .din(lres), .busy(obusy),
    .valid(out_valid), .stall(out_stall), .dout(odata)
  );
  assign action = odata.action;
  assign ack_matched = odata.ack_matched;
  assign ack_queue_full = odata.ack_queue_full;
  assign tx_dest = odata.tx.dest;
  assign tx_sender = odata.tx.sender;
  assign tx_type = odata.tx.ptype;
  assign tx_id = odata.tx.id;
  assign slot = odata.slot;
  assign last = odata.last;

  `include "mesh_packet_relay_table_assert.svh"
  `MPRT_ASSERT_IMP(a_load_in_emit, clk, rst, load, state == ST_EMIT)
  `MPRT_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, inbox_fill <= (IW+1)'(INBOX_DEPTH))
  `MPRT_ASSERT_NEXT(a_idle_after_last, clk, rst, load && lres.last, state == ST_IDLE)
endmodule
`default_nettype wire

// ===== rtl/mprt_out_reg.sv =====
// output register for result transfers
`default_nettype none
module mprt_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire mprt_pkg::result_t din,
  output logic                   busy,
  output logic                   valid,
  input  wire logic              stall,
  output mprt_pkg::result_t      dout
);
  import mprt_pkg::*;
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end
  assign busy = valid && stall;
endmodule
`default_nettype wire
